>>> rtl/pusq_pkg.sv
// Shared types, codes and helpers for the power unit startup sequencer.
package pusq_pkg;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 4;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    // event codes carried in s_tuser
    localparam logic [3:0] ACT_TICK    = 4'd0;
    localparam logic [3:0] ACT_START   = 4'd1;
    localparam logic [3:0] ACT_STOP    = 4'd2;
    localparam logic [3:0] ACT_DEINIT  = 4'd3;
    localparam logic [3:0] ACT_CLEAR   = 4'd4;
    localparam logic [3:0] ACT_ERRSTOP = 4'd5;
    localparam logic [3:0] ACT_ESTOP   = 4'd6;
    localparam logic [3:0] ACT_HOST    = 4'd7;
    localparam logic [3:0] ACT_STATUS  = 4'd8;
    localparam logic [3:0] ACT_H2      = 4'd9;
    localparam logic [3:0] ACT_WATER   = 4'd10;
    localparam logic [3:0] ACT_ERROR   = 4'd11;
    localparam logic [3:0] ACT_POWER   = 4'd12;
    localparam logic [3:0] ACT_BUBBLE  = 4'd13;
    localparam logic [3:0] ACT_FETCH   = 4'd14;

    // configuration register indexes
    localparam logic [2:0] REG_INIT_DELAY   = 3'd0;
    localparam logic [2:0] REG_POWER_ON     = 3'd1;
    localparam logic [2:0] REG_SHUTDOWN     = 3'd2;
    localparam logic [2:0] REG_POWER_OFF    = 3'd3;
    localparam logic [2:0] REG_BLINK        = 3'd4;
    localparam logic [2:0] REG_LINK_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_PRESS_LOW    = 3'd6;
    localparam logic [2:0] REG_PRESS_HIGH   = 3'd7;

    localparam logic [16:0] INIT_DELAY_RST   = 17'd800;
    localparam logic [16:0] POWER_ON_RST     = 17'd3000;
    localparam logic [16:0] SHUTDOWN_RST     = 17'd120000;
    localparam logic [16:0] POWER_OFF_RST    = 17'd6000;
    localparam logic [16:0] BLINK_RST        = 17'd100;
    localparam logic [7:0]  LINK_TIMEOUT_RST = 8'd200;
    localparam logic [12:0] PRESS_LOW_RST    = 13'd600;
    localparam logic [12:0] PRESS_HIGH_RST   = 13'd1000;

    // controller status codes
    localparam logic [7:0] STATUS_READY   = 8'd3;
    localparam logic [7:0] STATUS_CHARGED = 8'd6;
    localparam logic [7:0] STATUS_OFF     = 8'd9;

    localparam logic [9:0]  KW_MIN          = 10'd20;
    localparam logic [9:0]  KW_MAX          = 10'd655;
    localparam logic [15:0] KW_SCALE        = 16'd100;
    localparam logic [15:0] PRECHARGE_SETPT = 16'd2000;

    // lamp bits
    localparam logic [3:0] LAMP_G  = 4'b0001;
    localparam logic [3:0] LAMP_Y  = 4'b0010;
    localparam logic [3:0] LAMP_R  = 4'b0100;
    localparam logic [3:0] LAMP_BZ = 4'b1000;

    typedef struct packed {
        logic [16:0] init_delay;
        logic [16:0] power_on_wait;
        logic [16:0] shutdown_wait;
        logic [16:0] power_off_wait;
        logic [16:0] blink;
        logic [7:0]  link_timeout;
        logic [12:0] press_low;
        logic [12:0] press_high;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  action;
        logic        enable;
        logic [7:0]  ctrl_status;
        logic [15:0] h2_source_raw;
        logic [7:0]  error_level_in;
        logic [15:0] error_code_in;
        logic [9:0]  kw_request;
    } item_t;

    typedef struct packed {
        logic [2:0]  unit_state;
        logic [7:0]  error_level;
        logic [15:0] err_code;
        logic        start_flag;
        logic [15:0] power_setpoint;
        logic [3:0]  lamp_state;
        logic        power_24v;
        logic        ignition;
        logic        power_signal;
        logic        emergency_stop;
        logic        bubble_removal;
    } result_t;

    // x / 10 for a 16-bit value by reciprocal multiply (exact over the range)
    function automatic logic [12:0] div_by_10(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'd52429;
        return p[31:19];
    endfunction

endpackage

>>> rtl/pusq_cfg_regs.sv
// APB configuration registers of the sequencer.
module pusq_cfg_regs
    import pusq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_delay     <= INIT_DELAY_RST;
            cfg_reg.power_on_wait  <= POWER_ON_RST;
            cfg_reg.shutdown_wait  <= SHUTDOWN_RST;
            cfg_reg.power_off_wait <= POWER_OFF_RST;
            cfg_reg.blink          <= BLINK_RST;
            cfg_reg.link_timeout   <= LINK_TIMEOUT_RST;
            cfg_reg.press_low      <= PRESS_LOW_RST;
            cfg_reg.press_high     <= PRESS_HIGH_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INIT_DELAY:   cfg_reg.init_delay     <= pwdata[16:0];
                REG_POWER_ON:     cfg_reg.power_on_wait  <= pwdata[16:0];
                REG_SHUTDOWN:     cfg_reg.shutdown_wait  <= pwdata[16:0];
                REG_POWER_OFF:    cfg_reg.power_off_wait <= pwdata[16:0];
                REG_BLINK:        cfg_reg.blink          <= pwdata[16:0];
                REG_LINK_TIMEOUT: cfg_reg.link_timeout   <= pwdata[7:0];
                REG_PRESS_LOW:    cfg_reg.press_low      <= pwdata[12:0];
                REG_PRESS_HIGH:   cfg_reg.press_high     <= pwdata[12:0];
                default:          cfg_reg.press_high     <= cfg_reg.press_high;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_INIT_DELAY:   prdata = 32'(cfg_reg.init_delay);
            REG_POWER_ON:     prdata = 32'(cfg_reg.power_on_wait);
            REG_SHUTDOWN:     prdata = 32'(cfg_reg.shutdown_wait);
            REG_POWER_OFF:    prdata = 32'(cfg_reg.power_off_wait);
            REG_BLINK:        prdata = 32'(cfg_reg.blink);
            REG_LINK_TIMEOUT: prdata = 32'(cfg_reg.link_timeout);
            REG_PRESS_LOW:    prdata = 32'(cfg_reg.press_low);
            REG_PRESS_HIGH:   prdata = 32'(cfg_reg.press_high);
            default:          prdata = '0;
        endcase
    end

endmodule

>>> rtl/pusq_in_reg.sv
// Input register: captures one event transfer and unpacks its fields.
module pusq_in_reg
    import pusq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [IN_USER_W-1:0] s_tuser,
    input  logic                 advance,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.action         <= s_tuser;
            item_reg.enable         <= s_tdata[0];
            item_reg.ctrl_status    <= s_tdata[8:1];
            item_reg.h2_source_raw  <= s_tdata[24:9];
            item_reg.error_level_in <= s_tdata[32:25];
            item_reg.error_code_in  <= s_tdata[48:33];
            item_reg.kw_request     <= s_tdata[58:49];
        end
    end

endmodule

>>> rtl/pusq_core.sv
// Sequencer state and the single-pass next-state logic for one event.
module pusq_core
    import pusq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_IDLE      = 3'd1,
        ST_PRECHARGE = 3'd2,
        ST_RUNNING   = 3'd3,
        ST_SHUTDOWN  = 3'd4,
        ST_ERROR     = 3'd5,
        ST_DEINIT    = 3'd6,
        ST_NONE      = 3'd7
    } state_t;

    typedef struct packed {
        logic bubble;
        logic emerg;
        logic clear;
        logic deinit;
        logic start;
    } req_t;

    typedef struct packed {
        logic sig;
        logic ign;
        logic p24;
    } drive_t;

    state_t      cur_reg, cur_next;
    state_t      prev_reg, prev_next;
    logic        sub_reg, sub_next;
    logic [16:0] tick_reg, tick_next;
    logic [7:0]  upd_reg, upd_next;
    logic [7:0]  host_reg, host_next;
    req_t        rq_reg, rq_next;
    drive_t      dr_reg, dr_next;
    logic [7:0]  status_reg, status_next;
    logic [12:0] press_reg, press_next;
    logic [7:0]  flevel_reg, flevel_next;
    logic [15:0] fcode_reg, fcode_next;
    logic [15:0] setp_reg, setp_next;
    logic [3:0]  lamp_reg, lamp_next;

    logic        entry;
    logic        fault;
    logic [9:0]  kw_clamped;

    function automatic req_t set_start(input req_t rq, input logic en);
        req_t r;
        r = rq;
        if (r.start != en)
        begin
            r.deinit = 1'b0;
            r.start  = en;
            r.emerg  = 1'b0;
        end
        return r;
    endfunction

    always_comb
    begin
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        sub_next    = sub_reg;
        tick_next   = tick_reg;
        upd_next    = upd_reg;
        host_next   = host_reg;
        rq_next     = rq_reg;
        dr_next     = dr_reg;
        status_next = status_reg;
        press_next  = press_reg;
        flevel_next = flevel_reg;
        fcode_next  = fcode_reg;
        setp_next   = setp_reg;
        lamp_next   = lamp_reg;
        entry       = 1'b0;
        fault       = 1'b0;
        kw_clamped  = (item.kw_request > KW_MAX) ? KW_MAX : item.kw_request;

        case (item.action)
            ACT_TICK:
            begin
                entry = (prev_next != cur_next);
                if (entry)
                begin
                    prev_next = cur_next;
                end

                // entry actions
                case (cur_next)
                    ST_INIT:
                    begin
                        if (entry)
                        begin
                            lamp_next = LAMP_G | LAMP_Y | LAMP_R | LAMP_BZ;
                            tick_next = cfg.init_delay;
                            sub_next  = 1'b0;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (entry)
                        begin
                            lamp_next = LAMP_G;
                        end
                    end
                    ST_PRECHARGE:
                    begin
                        if (entry)
                        begin
                            lamp_next = LAMP_G | LAMP_Y;
                        end
                    end
                    ST_RUNNING:
                    begin
                        if (entry)
                        begin
                            lamp_next      = LAMP_Y;
                            rq_next.bubble = 1'b0;
                        end
                    end
                    ST_SHUTDOWN:
                    begin
                        if (entry)
                        begin
                            lamp_next = LAMP_G | LAMP_Y;
                            tick_next = cfg.shutdown_wait;
                            sub_next  = 1'b0;
                        end
                    end
                    ST_ERROR:
                    begin
                        if (entry)
                        begin
                            lamp_next = LAMP_R | LAMP_BZ;
                            tick_next = cfg.blink;
                        end
                    end
                    default:
                    begin
                        if (entry)
                        begin
                            dr_next.p24 = 1'b0;
                            dr_next.ign = 1'b0;
                        end
                    end
                endcase

                // controller fault and pressure window
                if (cur_next <= ST_SHUTDOWN)
                begin
                    if (flevel_next > 8'd1)
                    begin
                        fault    = 1'b1;
                        cur_next = ST_ERROR;
                        if (rq_next.start)
                        begin
                            rq_next.start = 1'b0;
                            rq_next.emerg = 1'b1;
                        end
                    end
                    else if (cur_next == ST_RUNNING &&
                             (press_next < cfg.press_low || press_next >= cfg.press_high))
                    begin
                        fault    = 1'b1;
                        rq_next  = set_start(rq_next, 1'b0);
                        cur_next = ST_ERROR;
                    end
                end

                if (!fault)
                begin
                    case (cur_next)
                        ST_INIT:
                        begin
                            if (!sub_next)
                            begin
                                if (tick_next == 17'd1)
                                begin
                                    tick_next   = cfg.power_on_wait;
                                    dr_next.p24 = 1'b1;
                                    dr_next.ign = 1'b1;
                                    dr_next.sig = 1'b1;
                                    sub_next    = 1'b1;
                                end
                            end
                            else if (status_next == STATUS_READY)
                            begin
                                cur_next = ST_IDLE;
                            end
                            else if (tick_next == 17'd1)
                            begin
                                cur_next = ST_ERROR;
                            end
                        end
                        ST_IDLE:
                        begin
                            if (rq_next.start)
                            begin
                                cur_next = ST_PRECHARGE;
                            end
                            else if (rq_next.deinit)
                            begin
                                cur_next = ST_SHUTDOWN;
                            end
                        end
                        ST_PRECHARGE:
                        begin
                            if (!rq_next.start)
                            begin
                                cur_next = ST_SHUTDOWN;
                            end
                            else if (status_next == STATUS_CHARGED)
                            begin
                                cur_next = ST_RUNNING;
                            end
                        end
                        ST_RUNNING:
                        begin
                            if (!rq_next.start)
                            begin
                                cur_next = ST_SHUTDOWN;
                            end
                        end
                        ST_SHUTDOWN:
                        begin
                            if (!sub_next)
                            begin
                                if (status_next == STATUS_READY)
                                begin
                                    tick_next   = cfg.power_off_wait;
                                    dr_next.sig = 1'b0;
                                    sub_next    = 1'b1;
                                end
                                else if (tick_next == 17'd1)
                                begin
                                    cur_next = ST_ERROR;
                                end
                            end
                            else if (status_next == STATUS_OFF)
                            begin
                                cur_next = rq_next.deinit ? ST_DEINIT : ST_INIT;
                            end
                            else if (tick_next == 17'd1)
                            begin
                                cur_next = ST_ERROR;
                            end
                        end
                        ST_ERROR:
                        begin
                            if (tick_next == 17'd1)
                            begin
                                lamp_next = lamp_next ^ (LAMP_R | LAMP_BZ);
                                tick_next = cfg.blink;
                            end
                            if (rq_next.clear)
                            begin
                                dr_next.p24   = 1'b0;
                                dr_next.ign   = 1'b0;
                                flevel_next   = '0;
                                fcode_next    = '0;
                                cur_next      = rq_next.deinit ? ST_DEINIT : ST_INIT;
                                rq_next.clear = 1'b0;
                            end
                        end
                        default:
                        begin
                            if (rq_next.start)
                            begin
                                cur_next = ST_INIT;
                            end
                        end
                    endcase
                end

                if (tick_next > 17'd1)
                begin
                    tick_next = tick_next - 17'd1;
                end

                // data update and host link timeouts
                if (cur_next > ST_INIT)
                begin
                    if (upd_next < cfg.link_timeout)
                    begin
                        upd_next = upd_next + 8'd1;
                        if (upd_next >= cfg.link_timeout && cur_next != ST_ERROR)
                        begin
                            rq_next  = set_start(rq_next, 1'b0);
                            cur_next = ST_ERROR;
                        end
                    end
                end
                else
                begin
                    upd_next = '0;
                end

                if (host_next < cfg.link_timeout)
                begin
                    host_next = host_next + 8'd1;
                    if (host_next >= cfg.link_timeout && cur_next != ST_ERROR)
                    begin
                        rq_next  = set_start(rq_next, 1'b0);
                        cur_next = ST_ERROR;
                    end
                end
            end
            ACT_START:
            begin
                rq_next = set_start(rq_next, 1'b1);
            end
            ACT_STOP:
            begin
                rq_next = set_start(rq_next, 1'b0);
            end
            ACT_DEINIT:
            begin
                rq_next.deinit = 1'b1;
                if (cur_next == ST_ERROR)
                begin
                    rq_next.clear = 1'b1;
                end
                if (rq_next.start)
                begin
                    rq_next.start = 1'b0;
                    rq_next.emerg = 1'b0;
                end
            end
            ACT_CLEAR:
            begin
                if (cur_next == ST_ERROR)
                begin
                    rq_next.clear = 1'b1;
                end
            end
            ACT_ERRSTOP:
            begin
                if (cur_next != ST_ERROR)
                begin
                    rq_next  = set_start(rq_next, 1'b0);
                    cur_next = ST_ERROR;
                end
            end
            ACT_ESTOP:
            begin
                if (rq_next.start)
                begin
                    rq_next.start = 1'b0;
                    rq_next.emerg = 1'b1;
                end
            end
            ACT_HOST:
            begin
                host_next = '0;
            end
            ACT_STATUS:
            begin
                status_next = item.ctrl_status;
                upd_next    = '0;
            end
            ACT_H2:
            begin
                press_next = div_by_10(item.h2_source_raw);
                upd_next   = '0;
            end
            ACT_WATER:
            begin
                upd_next = '0;
            end
            ACT_ERROR:
            begin
                flevel_next = item.error_level_in;
                fcode_next  = item.error_code_in;
                upd_next    = '0;
            end
            ACT_POWER:
            begin
                if (item.kw_request >= KW_MIN)
                begin
                    setp_next = 16'(kw_clamped) * KW_SCALE;
                end
            end
            ACT_BUBBLE:
            begin
                if (cur_next != ST_RUNNING)
                begin
                    rq_next.bubble = item.enable;
                end
            end
            ACT_FETCH:
            begin
                if (cur_next == ST_PRECHARGE)
                begin
                    setp_next = PRECHARGE_SETPT;
                end
            end
            default:
            begin
                setp_next = setp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= ST_INIT;
            prev_reg   <= ST_NONE;
            sub_reg    <= 1'b0;
            tick_reg   <= '0;
            upd_reg    <= '0;
            host_reg   <= '0;
            rq_reg     <= '0;
            dr_reg     <= '0;
            status_reg <= '0;
            press_reg  <= '0;
            flevel_reg <= '0;
            fcode_reg  <= '0;
            setp_reg   <= '0;
            lamp_reg   <= '0;
        end
        else if (step)
        begin
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            sub_reg    <= sub_next;
            tick_reg   <= tick_next;
            upd_reg    <= upd_next;
            host_reg   <= host_next;
            rq_reg     <= rq_next;
            dr_reg     <= dr_next;
            status_reg <= status_next;
            press_reg  <= press_next;
            flevel_reg <= flevel_next;
            fcode_reg  <= fcode_next;
            setp_reg   <= setp_next;
            lamp_reg   <= lamp_next;
        end
    end

    always_comb
    begin
        result.unit_state     = cur_next;
        result.error_level    = flevel_next;
        result.err_code       = fcode_next;
        result.start_flag     = rq_next.start;
        result.power_setpoint = setp_next;
        result.lamp_state     = lamp_next;
        result.power_24v      = dr_next.p24;
        result.ignition       = dr_next.ign;
        result.power_signal   = dr_next.sig;
        result.emergency_stop = rq_next.emerg;
        result.bubble_removal = rq_next.bubble;
    end

endmodule

>>> rtl/pusq_out_reg.sv
// Result register: holds one snapshot until the receiver takes it.
module pusq_out_reg
    import pusq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               result,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    result_t res_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'd0,
                       res_reg.bubble_removal,
                       res_reg.emergency_stop,
                       res_reg.power_signal,
                       res_reg.ignition,
                       res_reg.power_24v,
                       res_reg.lamp_state,
                       res_reg.power_setpoint,
                       res_reg.start_flag,
                       res_reg.err_code,
                       res_reg.error_level,
                       res_reg.unit_state};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

>>> rtl/power_unit_startup_sequencer_top.sv
// Top level of the fuel-cell power unit startup sequencer.
//
// Events enter on the s_ stream: tuser carries the event code (tick, host
// request or controller report), tdata its arguments. Every accepted event
// produces exactly one snapshot transfer on the m_ stream.
// Configuration registers sit on the APB port at byte address 4*index;
// write them only while no event is in flight.
//
// An event passes the input register, then one pass of next-state logic
// into the state and result registers, before m_tvalid rises.
// Throughput: one event per cycle while the receiver keeps up; the rate
// is set by the state update loop, which handles each event in one pass.
// Reset puts the sequencer in init with all flags clear and the registers
// at their defaults. When the receiver stalls, the result register holds
// its snapshot and the input register takes one more event; s_tready then
// drops until the result is taken.
module power_unit_startup_sequencer_top
    import pusq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] enable, [8:1] ctrl_status, [24:9] h2_source_raw,
    // [32:25] error_level_in, [48:33] error_code_in, [58:49] kw_request
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [3:0] action
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [2:0] unit_state, [10:3] error_level, [26:11] err_code,
    // [27] start_flag, [43:28] power_setpoint, [47:44] lamp_state,
    // [48] power_24v, [49] ignition, [50] power_signal,
    // [51] emergency_stop, [52] bubble_removal
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    advance;
    logic    step;

    assign advance = !m_tvalid || m_tready;
    assign step    = item_valid && advance;

    pusq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pusq_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pusq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    pusq_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> bench/tb_power_unit_startup_sequencer_top.sv
// Self-checking bench for the power unit startup sequencer: event stream in, snapshot stream out.
module tb_power_unit_startup_sequencer_top;
    import pusq_pkg::*;

    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_PRECHARGE = 3'd2;
    localparam logic [2:0] S_RUNNING   = 3'd3;
    localparam logic [2:0] S_SHUTDOWN  = 3'd4;
    localparam logic [2:0] S_ERROR     = 3'd5;
    localparam logic [2:0] S_DEINIT    = 3'd6;
    localparam logic [2:0] S_NONE      = 3'd7;

    localparam logic [3:0] ACT_UNUSED  = 4'd15;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // sequencer shadow
    cfg_t        cfg;
    logic [2:0]  seq_state, last_state;
    logic        phase_bit;
    logic [16:0] timer;
    logic [7:0]  upd_idle, host_idle;
    logic        rq_start, rq_deinit, rq_clear, rq_emerg, rq_bubble;
    logic        drv_24v, drv_ign, drv_sig;
    logic [7:0]  stat_code;
    logic [12:0] h2_kpa;
    logic [7:0]  flt_level;
    logic [15:0] flt_code;
    logic [15:0] setpt;
    logic [3:0]  lamps;

    item_t       item_fifo[$];
    result_t     snapshot_fifo[$];
    item_t       cur_item;
    result_t     seen, wanted;
    string       diffs;
    int unsigned err_count   = 0;
    int unsigned taken_count = 0;
    int unsigned phase_items = 0;
    int unsigned src_gap     = 0;
    int unsigned sink_gap    = 0;
    logic        gaps_on     = 1'b1;
    logic        sink_hold   = 1'b0;

    power_unit_startup_sequencer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic reset_shadow();
        cfg.init_delay     = INIT_DELAY_RST;
        cfg.power_on_wait  = POWER_ON_RST;
        cfg.shutdown_wait  = SHUTDOWN_RST;
        cfg.power_off_wait = POWER_OFF_RST;
        cfg.blink          = BLINK_RST;
        cfg.link_timeout   = LINK_TIMEOUT_RST;
        cfg.press_low      = PRESS_LOW_RST;
        cfg.press_high     = PRESS_HIGH_RST;
        seq_state  = S_INIT;
        last_state = S_NONE;
        phase_bit  = 1'b0;
        timer      = '0;
        upd_idle   = '0;
        host_idle  = '0;
        {rq_start, rq_deinit, rq_clear, rq_emerg, rq_bubble} = '0;
        {drv_24v, drv_ign, drv_sig} = '0;
        stat_code  = '0;
        h2_kpa     = '0;
        flt_level  = '0;
        flt_code   = '0;
        setpt      = '0;
        lamps      = '0;
    endtask

    // host start/stop request; a change drops deinit and emergency
    function void set_run_request(input logic en);
        if (rq_start != en)
        begin
            rq_deinit = 1'b0;
            rq_emerg  = 1'b0;
            rq_start  = en;
        end
    endfunction

    function void force_error();
        if (seq_state != S_ERROR)
        begin
            set_run_request(1'b0);
            seq_state = S_ERROR;
        end
    endfunction

    function void latch_estop();
        if (rq_start)
        begin
            rq_start = 1'b0;
            rq_emerg = 1'b1;
        end
    endfunction

    function bit just_entered();
        if (last_state != seq_state)
        begin
            last_state = seq_state;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function bit fault_trip();
        if (flt_level > 8'd1)
        begin
            seq_state = S_ERROR;
            latch_estop();
            return 1'b1;
        end
        if (seq_state == S_RUNNING &&
            (h2_kpa < cfg.press_low || h2_kpa >= cfg.press_high))
        begin
            set_run_request(1'b0);
            seq_state = S_ERROR;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void step_state();
        case (seq_state)
            S_INIT:
            begin
                if (just_entered())
                begin
                    lamps     = LAMP_G | LAMP_Y | LAMP_R | LAMP_BZ;
                    timer     = cfg.init_delay;
                    phase_bit = 1'b0;
                end
                if (!fault_trip())
                begin
                    if (!phase_bit)
                    begin
                        if (timer == 17'd1)
                        begin
                            timer     = cfg.power_on_wait;
                            drv_24v   = 1'b1;
                            drv_ign   = 1'b1;
                            drv_sig   = 1'b1;
                            phase_bit = 1'b1;
                        end
                    end
                    else if (stat_code == STATUS_READY)
                        seq_state = S_IDLE;
                    else if (timer == 17'd1)
                        seq_state = S_ERROR;
                end
            end
            S_IDLE:
            begin
                if (just_entered())
                    lamps = LAMP_G;
                if (!fault_trip())
                begin
                    if (rq_start)
                        seq_state = S_PRECHARGE;
                    else if (rq_deinit)
                        seq_state = S_SHUTDOWN;
                end
            end
            S_PRECHARGE:
            begin
                if (just_entered())
                    lamps = LAMP_G | LAMP_Y;
                if (!fault_trip())
                begin
                    if (stat_code == STATUS_CHARGED)
                        seq_state = S_RUNNING;
                    if (!rq_start)
                        seq_state = S_SHUTDOWN;
                end
            end
            S_RUNNING:
            begin
                if (just_entered())
                begin
                    lamps     = LAMP_Y;
                    rq_bubble = 1'b0;
                end
                if (!fault_trip())
                begin
                    if (!rq_start)
                        seq_state = S_SHUTDOWN;
                end
            end
            S_SHUTDOWN:
            begin
                if (just_entered())
                begin
                    lamps     = LAMP_G | LAMP_Y;
                    timer     = cfg.shutdown_wait;
                    phase_bit = 1'b0;
                end
                if (!fault_trip())
                begin
                    if (!phase_bit)
                    begin
                        if (stat_code == STATUS_READY)
                        begin
                            timer     = cfg.power_off_wait;
                            drv_sig   = 1'b0;
                            phase_bit = 1'b1;
                        end
                        else if (timer == 17'd1)
                            seq_state = S_ERROR;
                    end
                    else if (stat_code == STATUS_OFF)
                        seq_state = rq_deinit ? S_DEINIT : S_INIT;
                    else if (timer == 17'd1)
                        seq_state = S_ERROR;
                end
            end
            S_ERROR:
            begin
                if (just_entered())
                begin
                    lamps = LAMP_R | LAMP_BZ;
                    timer = cfg.blink;
                end
                if (timer == 17'd1)
                begin
                    lamps ^= (LAMP_R | LAMP_BZ);
                    timer = cfg.blink;
                end
                if (rq_clear)
                begin
                    drv_24v   = 1'b0;
                    drv_ign   = 1'b0;
                    flt_level = '0;
                    flt_code  = '0;
                    seq_state = rq_deinit ? S_DEINIT : S_INIT;
                    rq_clear  = 1'b0;
                end
            end
            default:
            begin
                if (just_entered())
                begin
                    drv_24v = 1'b0;
                    drv_ign = 1'b0;
                end
                if (rq_start)
                    seq_state = S_INIT;
            end
        endcase
    endfunction

    function void tick_update();
        step_state();
        if (timer > 17'd1)
            timer = timer - 17'd1;
        if (seq_state > S_INIT)
        begin
            if (upd_idle < cfg.link_timeout)
            begin
                upd_idle = upd_idle + 8'd1;
                if (upd_idle >= cfg.link_timeout)
                    force_error();
            end
        end
        else
        begin
            upd_idle = '0;
        end
        if (host_idle < cfg.link_timeout)
        begin
            host_idle = host_idle + 8'd1;
            if (host_idle >= cfg.link_timeout)
                force_error();
        end
    endfunction

    function result_t sequence_event(input item_t it);
        logic [9:0] kw;
        result_t    r;
        case (it.action)
            ACT_TICK:    tick_update();
            ACT_START:   set_run_request(1'b1);
            ACT_STOP:    set_run_request(1'b0);
            ACT_DEINIT:
            begin
                rq_deinit = 1'b1;
                if (seq_state == S_ERROR)
                    rq_clear = 1'b1;
                if (rq_start)
                begin
                    rq_start = 1'b0;
                    rq_emerg = 1'b0;
                end
            end
            ACT_CLEAR:   if (seq_state == S_ERROR) rq_clear = 1'b1;
            ACT_ERRSTOP: force_error();
            ACT_ESTOP:   latch_estop();
            ACT_HOST:    host_idle = '0;
            ACT_STATUS:
            begin
                stat_code = it.ctrl_status;
                upd_idle  = '0;
            end
            ACT_H2:
            begin
                h2_kpa   = 13'(it.h2_source_raw / 16'd10);
                upd_idle = '0;
            end
            ACT_WATER:   upd_idle = '0;
            ACT_ERROR:
            begin
                flt_level = it.error_level_in;
                flt_code  = it.error_code_in;
                upd_idle  = '0;
            end
            ACT_POWER:
            begin
                kw = it.kw_request;
                if (kw >= KW_MIN)
                begin
                    if (kw > KW_MAX)
                        kw = KW_MAX;
                    setpt = 16'(kw) * KW_SCALE;
                end
            end
            ACT_BUBBLE:  if (seq_state != S_RUNNING) rq_bubble = it.enable;
            ACT_FETCH:   if (seq_state == S_PRECHARGE) setpt = PRECHARGE_SETPT;
            default: ;
        endcase
        r.unit_state     = seq_state;
        r.error_level    = flt_level;
        r.err_code       = flt_code;
        r.start_flag     = rq_start;
        r.power_setpoint = setpt;
        r.lamp_state     = lamps;
        r.power_24v      = drv_24v;
        r.ignition       = drv_ign;
        r.power_signal   = drv_sig;
        r.emergency_stop = rq_emerg;
        r.bubble_removal = rq_bubble;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(input item_t e);
        logic [IN_DATA_W-1:0] d;
        d        = '0;
        d[0]     = e.enable;
        d[8:1]   = e.ctrl_status;
        d[24:9]  = e.h2_source_raw;
        d[32:25] = e.error_level_in;
        d[48:33] = e.error_code_in;
        d[58:49] = e.kw_request;
        return d;
    endfunction

    function automatic result_t unpack_snapshot(input logic [OUT_DATA_W-1:0] d);
        result_t r;
        r.unit_state     = d[2:0];
        r.error_level    = d[10:3];
        r.err_code       = d[26:11];
        r.start_flag     = d[27];
        r.power_setpoint = d[43:28];
        r.lamp_state     = d[47:44];
        r.power_24v      = d[48];
        r.ignition       = d[49];
        r.power_signal   = d[50];
        r.emergency_stop = d[51];
        r.bubble_removal = d[52];
        return r;
    endfunction

    function automatic string snapshot_diffs(input result_t w, input result_t g);
        string s;
        s = "";
        if (g.unit_state !== w.unit_state)
            s = {s, $sformatf(" unit_state exp %0d got %0d", w.unit_state, g.unit_state)};
        if (g.error_level !== w.error_level)
            s = {s, $sformatf(" error_level exp %0d got %0d", w.error_level, g.error_level)};
        if (g.err_code !== w.err_code)
            s = {s, $sformatf(" err_code exp %0h got %0h", w.err_code, g.err_code)};
        if (g.start_flag !== w.start_flag)
            s = {s, $sformatf(" start_flag exp %0b got %0b", w.start_flag, g.start_flag)};
        if (g.power_setpoint !== w.power_setpoint)
            s = {s, $sformatf(" power_setpoint exp %0d got %0d",
                              w.power_setpoint, g.power_setpoint)};
        if (g.lamp_state !== w.lamp_state)
            s = {s, $sformatf(" lamp_state exp %b got %b", w.lamp_state, g.lamp_state)};
        if (g.power_24v !== w.power_24v)
            s = {s, $sformatf(" power_24v exp %0b got %0b", w.power_24v, g.power_24v)};
        if (g.ignition !== w.ignition)
            s = {s, $sformatf(" ignition exp %0b got %0b", w.ignition, g.ignition)};
        if (g.power_signal !== w.power_signal)
            s = {s, $sformatf(" power_signal exp %0b got %0b", w.power_signal, g.power_signal)};
        if (g.emergency_stop !== w.emergency_stop)
            s = {s, $sformatf(" emergency_stop exp %0b got %0b",
                              w.emergency_stop, g.emergency_stop)};
        if (g.bubble_removal !== w.bubble_removal)
            s = {s, $sformatf(" bubble_removal exp %0b got %0b",
                              w.bubble_removal, g.bubble_removal)};
        return s;
    endfunction

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    // source side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                snapshot_fifo.push_back(sequence_event(cur_item));
                taken_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (item_fifo.size() > 0)
                begin
                    cur_item = item_fifo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_item(cur_item);
                    s_tuser  <= cur_item.action;
                    if (gaps_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 4);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen = unpack_snapshot(m_tdata);
                if (snapshot_fifo.size() == 0)
                begin
                    note_error($sformatf("unexpected snapshot transfer %h", m_tdata));
                end
                else
                begin
                    wanted = snapshot_fifo.pop_front();
                    diffs  = snapshot_diffs(wanted, seen);
                    if (diffs != "")
                        note_error({"snapshot mismatch:", diffs});
                end
            end
            if (sink_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (gaps_on && $urandom_range(0, 6) == 0)
                    sink_gap = $urandom_range(1, 4);
            end
        end
    end

    // long sink stall while the source keeps offering
    initial
    begin : long_stall
        int unsigned k;
        for (k = 0; k < 2; k++)
        begin
            while (!(taken_count >= 300 + 700 * k && item_fifo.size() > 40))
                @(posedge clk);
            sink_hold <= 1'b1;
            repeat (80) @(posedge clk);
            sink_hold <= 1'b0;
        end
    end

    function automatic item_t noise_item();
        item_t e;
        e.action         = 4'($urandom_range(0, 15));
        e.enable         = 1'($urandom_range(0, 1));
        e.ctrl_status    = 8'($urandom);
        e.h2_source_raw  = 16'($urandom);
        e.error_level_in = 8'($urandom);
        e.error_code_in  = 16'($urandom);
        e.kw_request     = 10'($urandom);
        return e;
    endfunction

    task automatic push_item(input item_t e);
        item_fifo.push_back(e);
        phase_items++;
        if ($urandom_range(0, 24) == 0)
        begin
            item_fifo.push_back(noise_item());
            phase_items++;
        end
    endtask

    task automatic push_act(input logic [3:0] a);
        item_t e;
        e = noise_item();
        e.action = a;
        push_item(e);
    endtask

    task automatic push_status(input logic [7:0] code);
        item_t e;
        e = noise_item();
        e.action      = ACT_STATUS;
        e.ctrl_status = code;
        push_item(e);
    endtask

    task automatic push_fault(input logic [7:0] lvl);
        item_t e;
        e = noise_item();
        e.action         = ACT_ERROR;
        e.error_level_in = lvl;
        push_item(e);
    endtask

    task automatic push_h2(input logic in_window);
        item_t       e;
        int unsigned kpa, raw;
        e = noise_item();
        e.action = ACT_H2;
        if (in_window)
            kpa = (cfg.press_high > cfg.press_low) ?
                  $urandom_range(cfg.press_low, cfg.press_high - 13'd1) : cfg.press_low;
        else if (cfg.press_low > 0 && $urandom_range(0, 1) == 1)
            kpa = $urandom_range(0, cfg.press_low - 13'd1);
        else
            kpa = $urandom_range(cfg.press_high, 6553);
        raw = kpa * 10 + $urandom_range(0, 9);
        e.h2_source_raw = (raw > 65535) ? 16'hFFFF : 16'(raw);
        push_item(e);
    endtask

    task automatic push_power();
        item_t e;
        e = noise_item();
        e.action = ACT_POWER;
        case ($urandom_range(0, 3))
            0:       e.kw_request = 10'($urandom_range(0, 19));
            3:       e.kw_request = 10'($urandom_range(656, 1023));
            default: e.kw_request = 10'($urandom_range(20, 655));
        endcase
        push_item(e);
    endtask

    // ticks with host and data keepalives in between
    task automatic push_ticks(input int n);
        repeat (n)
        begin
            if ($urandom_range(0, 3) != 0)
                push_act(ACT_HOST);
            case ($urandom_range(0, 3))
                0:       push_act(ACT_WATER);
                1:       push_h2(1'b1);
                2:       push_fault(8'($urandom_range(0, 1)));
                default: ;
            endcase
            push_act(ACT_TICK);
        end
    endtask

    // one power-up, run and power-down cycle as a host would drive it
    task automatic push_session();
        int unsigned n_init;
        if ($urandom_range(0, 2) == 0)
        begin
            push_act(ACT_ERRSTOP);
            push_ticks(1);
            push_act(ACT_CLEAR);
            push_ticks(1);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_act(ACT_START);
            push_ticks(1);
        end
        push_act(ACT_HOST);
        push_h2(1'b1);
        push_status('0);
        push_fault(8'($urandom_range(0, 1)));
        n_init = (cfg.init_delay > 17'd30) ? 30 : int'(cfg.init_delay);
        push_ticks(n_init + $urandom_range(1, 2));
        push_status(STATUS_READY);
        push_ticks($urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0)
            push_act(ACT_DEINIT);
        push_act(ACT_BUBBLE);
        push_act(ACT_START);
        push_ticks(1);
        push_act(ACT_FETCH);
        push_power();
        push_status(STATUS_CHARGED);
        push_ticks($urandom_range(1, 3));
        repeat ($urandom_range(2, 12))
        begin
            case ($urandom_range(0, 7))
                0:       push_act(ACT_BUBBLE);
                1:       push_power();
                2:       push_act(ACT_FETCH);
                default: ;
            endcase
            push_ticks(1);
        end
        case ($urandom_range(0, 6))
            0, 1:    push_act(ACT_STOP);
            2:       push_act(ACT_DEINIT);
            3:       push_act(ACT_ESTOP);
            4:       push_act(ACT_ERRSTOP);
            5:       push_h2(1'b0);
            default: push_fault(8'($urandom_range(2, 255)));
        endcase
        push_ticks($urandom_range(1, 3));
        push_status(STATUS_READY);
        push_ticks($urandom_range(1, 3));
        push_status(STATUS_OFF);
        push_ticks($urandom_range(1, 3));
        if ($urandom_range(0, 1) == 1)
        begin
            push_act(($urandom_range(0, 1) == 1) ? ACT_CLEAR : ACT_DEINIT);
            push_ticks($urandom_range(1, 3));
        end
    endtask

    task automatic push_directed(input logic [3:0] a, input logic [31:0] arg);
        item_t e;
        e.action         = a;
        e.enable         = arg[0];
        e.ctrl_status    = arg[7:0];
        e.h2_source_raw  = arg[15:0];
        e.error_level_in = arg[7:0];
        e.error_code_in  = arg[31:16];
        e.kw_request     = arg[9:0];
        item_fifo.push_back(e);
    endtask

    task automatic drain();
        while (item_fifo.size() != 0 || s_tvalid || snapshot_fifo.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INIT_DELAY:   cfg.init_delay     = val[16:0];
            REG_POWER_ON:     cfg.power_on_wait  = val[16:0];
            REG_SHUTDOWN:     cfg.shutdown_wait  = val[16:0];
            REG_POWER_OFF:    cfg.power_off_wait = val[16:0];
            REG_BLINK:        cfg.blink          = val[16:0];
            REG_LINK_TIMEOUT: cfg.link_timeout   = val[7:0];
            REG_PRESS_LOW:    cfg.press_low      = val[12:0];
            default:          cfg.press_high     = val[12:0];
        endcase
    endtask

    task automatic program_regs(input logic [16:0] init_d, input logic [16:0] on_w,
                                input logic [16:0] shut_w, input logic [16:0] off_w,
                                input logic [16:0] blink_t, input logic [7:0] link_t,
                                input logic [12:0] lo, input logic [12:0] hi);
        write_reg(REG_INIT_DELAY, 32'(init_d));
        write_reg(REG_POWER_ON, 32'(on_w));
        write_reg(REG_SHUTDOWN, 32'(shut_w));
        write_reg(REG_POWER_OFF, 32'(off_w));
        write_reg(REG_BLINK, 32'(blink_t));
        write_reg(REG_LINK_TIMEOUT, 32'(link_t));
        write_reg(REG_PRESS_LOW, 32'(lo));
        write_reg(REG_PRESS_HIGH, 32'(hi));
        phase_items = 0;
    endtask

    initial
    begin : stimulus
        logic [12:0] lo;
        reset_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass at reset defaults
        push_directed(ACT_TICK, 0);
        push_directed(ACT_HOST, 0);
        push_directed(ACT_WATER, 0);
        push_directed(ACT_STATUS, 255);
        push_directed(ACT_STATUS, 0);
        push_directed(ACT_H2, 65535);
        push_directed(ACT_H2, 0);
        push_directed(ACT_POWER, 19);
        push_directed(ACT_POWER, 20);
        push_directed(ACT_POWER, 1023);
        push_directed(ACT_POWER, 655);
        push_directed(ACT_BUBBLE, 1);
        push_directed(ACT_BUBBLE, 0);
        push_directed(ACT_FETCH, 0);
        push_directed(ACT_CLEAR, 0);
        push_directed(ACT_START, 0);
        push_directed(ACT_ESTOP, 0);
        push_directed(ACT_STOP, 0);
        push_directed(ACT_DEINIT, 0);
        push_directed(ACT_ERROR, 32'hFFFF_FFFF);
        push_directed(ACT_TICK, 0);
        push_directed(ACT_ERRSTOP, 0);
        push_directed(ACT_CLEAR, 0);
        push_directed(ACT_TICK, 0);
        push_directed(ACT_ERROR, 0);
        push_directed(ACT_UNUSED, 32'hFFFF_FFFF);
        drain();

        program_regs(2, 4, 6, 6, 2, 30, 600, 1000);
        while (phase_items < 400)
            push_session();
        drain();

        gaps_on <= 1'b0;
        lo = 13'($urandom_range(0, 3000));
        program_regs(17'($urandom_range(1, 8)), 17'($urandom_range(2, 10)),
                     17'($urandom_range(2, 10)), 17'($urandom_range(2, 10)),
                     17'($urandom_range(1, 5)), 8'($urandom_range(10, 60)),
                     lo, 13'($urandom_range(lo + 1, 6553)));
        while (phase_items < 400)
            push_session();
        drain();

        gaps_on <= 1'b1;
        program_regs(1, 1, 1, 1, 1, 255, 0, 6553);
        while (phase_items < 250)
            push_session();
        drain();

        // zero timers and timeouts never expire
        program_regs(0, 0, 0, 0, 0, 0, 0, 0);
        while (phase_items < 200)
        begin
            if ($urandom_range(0, 1) == 1)
                push_session();
            else
                push_item(noise_item());
        end
        drain();

        program_regs(131071, 131071, 131071, 131071, 131071, 255, 6553, 6553);
        while (phase_items < 150)
            push_item(noise_item());
        drain();

        gaps_on <= 1'b0;
        program_regs(3, 5, 4, 4, 3, 40, 500, 2000);
        while (phase_items < 200)
            push_session();
        drain();

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
